// ----- hdl/oaht_pkg.sv -----
// Shared types, constants and the hash function of the open-addressed hash table.
package oaht_pkg;

   localparam int SLOT_W     = 10;
   localparam int TABLE_SIZE = 1 << SLOT_W;
   localparam int PROBE_STEP = 37;
   localparam int HASH_SHIFT = 31;
   localparam int KEY_W      = 48;
   localparam int SIZE_W     = 32;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_DELETE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      FSM_CLEAR = 3'b001,
      FSM_IDLE  = 3'b010,
      FSM_PROBE = 3'b100
   } fsm_type;

   // Slot mark bits held per entry
   typedef struct packed {
      logic used;
      logic deleted;
   } mark_type;

   function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] mix;
      mix = key ^ (key >> HASH_SHIFT);
      return mix[SLOT_W-1:0];
   endfunction

endpackage

// ----- hdl/open_addressed_hash_table_top.sv -----
// Open-addressed hash table top level: mark and entry memories with a probe sequencer.
//
// Takes one transaction at a time: start is accepted while busy is low, and busy stays high
// until the result strobe. The probe loop reads one slot per cycle from the mark and entry
// memories; a transaction probes from one slot (a home-slot hit or an empty home slot) up to
// TABLE_SIZE = 1024 slots in the worst case. The result appears on the rsp_ ports for one
// cycle with rsp_valid high, in the cycle in which busy drops, and must be taken then. After
// reset a clearing pass walks the mark memory one slot per cycle and holds busy high until
// every slot is cleared, so no transaction is accepted before then.
module open_addressed_hash_table_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_action,
   input  logic [oaht_pkg::KEY_W-1:0]      req_key,
   input  logic [oaht_pkg::SIZE_W-1:0]     req_size_in,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic [oaht_pkg::SIZE_W-1:0]     rsp_stored_size,
   output logic [oaht_pkg::SLOT_W-1:0]     rsp_slot_index
);

   localparam int ENTRY_W = oaht_pkg::KEY_W + oaht_pkg::SIZE_W;
   localparam logic [oaht_pkg::SLOT_W-1:0] LAST_SLOT = oaht_pkg::SLOT_W'(oaht_pkg::TABLE_SIZE - 1);
   localparam logic [oaht_pkg::SLOT_W-1:0] STEP      = oaht_pkg::SLOT_W'(oaht_pkg::PROBE_STEP);

   // Memories
   oaht_pkg::mark_type          mark_mem_ff  [oaht_pkg::TABLE_SIZE];
   logic [ENTRY_W-1:0]          entry_mem_ff [oaht_pkg::TABLE_SIZE];
   oaht_pkg::mark_type          mark_rd_ff;
   logic [ENTRY_W-1:0]          entry_rd_ff;

   // Control and transaction registers
   oaht_pkg::fsm_type           state_ff, state_in;
   logic [oaht_pkg::SLOT_W-1:0] probe_addr_ff, probe_addr_in;
   logic [oaht_pkg::SLOT_W-1:0] probe_cnt_ff, probe_cnt_in;
   logic [oaht_pkg::SLOT_W-1:0] clear_addr_ff, clear_addr_in;
   logic [1:0]                  action_ff;
   logic [oaht_pkg::KEY_W-1:0]  key_ff;
   logic [oaht_pkg::SIZE_W-1:0] size_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   oaht_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [oaht_pkg::SIZE_W-1:0] rsp_size_ff, rsp_size_in;
   logic [oaht_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // Memory write ports
   logic                        mark_we;
   logic [oaht_pkg::SLOT_W-1:0] mark_wa;
   oaht_pkg::mark_type          mark_wd;
   logic                        entry_we;

   logic                        accept;
   logic                        key_match;
   logic                        last_probe;
   logic [oaht_pkg::KEY_W-1:0]  rd_key;
   logic [oaht_pkg::SIZE_W-1:0] rd_size;

   assign accept     = start && (state_ff == oaht_pkg::FSM_IDLE);
   assign rd_key     = entry_rd_ff[ENTRY_W-1:oaht_pkg::SIZE_W];
   assign rd_size    = entry_rd_ff[oaht_pkg::SIZE_W-1:0];
   assign key_match  = (rd_key == key_ff);
   assign last_probe = (probe_cnt_ff == LAST_SLOT);

   always_comb begin
      state_in      = state_ff;
      probe_addr_in = probe_addr_ff;
      probe_cnt_in  = probe_cnt_ff;
      clear_addr_in = clear_addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_slot_in   = rsp_slot_ff;
      mark_we       = 1'b0;
      mark_wa       = probe_addr_ff;
      mark_wd       = '{used: 1'b0, deleted: 1'b0};
      entry_we      = 1'b0;

      case (state_ff)
         oaht_pkg::FSM_CLEAR: begin
            mark_we       = 1'b1;
            mark_wa       = clear_addr_ff;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == LAST_SLOT) begin
               state_in = oaht_pkg::FSM_IDLE;
            end
         end
         oaht_pkg::FSM_IDLE: begin
            probe_addr_in = oaht_pkg::home_slot(req_key);
            probe_cnt_in  = '0;
            if (start) begin
               state_in = oaht_pkg::FSM_PROBE;
            end
         end
         oaht_pkg::FSM_PROBE: begin
            rsp_status_in = oaht_pkg::ST_NOT_FOUND;
            rsp_size_in   = '0;
            rsp_slot_in   = '0;
            case (action_ff)
               oaht_pkg::ACT_INSERT: begin
                  if (!mark_rd_ff.used) begin
                     mark_we       = 1'b1;
                     mark_wd       = '{used: 1'b1, deleted: mark_rd_ff.deleted};
                     entry_we      = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = oaht_pkg::ST_OK;
                     rsp_slot_in   = probe_addr_ff;
                  end else if (last_probe) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = oaht_pkg::ST_FULL;
                  end
               end
               oaht_pkg::ACT_LOOKUP, oaht_pkg::ACT_DELETE: begin
                  if (mark_rd_ff.used && key_match) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = oaht_pkg::ST_OK;
                     rsp_size_in   = rd_size;
                     rsp_slot_in   = probe_addr_ff;
                     if (action_ff == oaht_pkg::ACT_DELETE) begin
                        mark_we = 1'b1;
                        mark_wd = '{used: 1'b0, deleted: 1'b1};
                     end
                  end else if ((!mark_rd_ff.used && !mark_rd_ff.deleted) || last_probe) begin
                     rsp_valid_in = 1'b1;
                  end
               end
               default: begin
                  // Unknown action: report not found, leave the table alone
                  rsp_valid_in = 1'b1;
               end
            endcase
            if (rsp_valid_in) begin
               state_in = oaht_pkg::FSM_IDLE;
            end else begin
               probe_addr_in = probe_addr_ff + STEP;
               probe_cnt_in  = probe_cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = oaht_pkg::FSM_IDLE;
         end
      endcase
   end

   // Memories: one write port each, registered read at the next probe address
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem_ff[mark_wa] <= mark_wd;
      end
      mark_rd_ff <= mark_mem_ff[probe_addr_in];
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem_ff[probe_addr_ff] <= {key_ff, size_ff};
      end
      entry_rd_ff <= entry_mem_ff[probe_addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= oaht_pkg::FSM_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_addr_ff <= probe_addr_in;
      probe_cnt_ff  <= probe_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_slot_ff   <= rsp_slot_in;
      if (accept) begin
         action_ff <= req_action;
         key_ff    <= req_key;
         size_ff   <= req_size_in;
      end
   end

   assign busy            = (state_ff != oaht_pkg::FSM_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_stored_size = rsp_size_ff;
   assign rsp_slot_index  = rsp_slot_ff;

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == oaht_pkg::FSM_CLEAR) |-> !rsp_valid_ff)
      else $error("result strobe during clearing pass");

   a_accept_starts_probe: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == oaht_pkg::FSM_PROBE))
      else $error("accepted transaction did not start probing");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == oaht_pkg::FSM_IDLE))
      else $error("result strobe while busy");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != oaht_pkg::ST_OK))
         |-> (rsp_size_ff == '0 && rsp_slot_ff == '0))
      else $error("failed transaction carries a size or slot");

   a_probe_walk: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == oaht_pkg::FSM_PROBE) && !rsp_valid_in)
         |=> (probe_addr_ff == $past(probe_addr_ff) + STEP))
      else $error("probe did not advance by the step");

endmodule
